// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked only outside reset
`define FCS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Property that must also hold across reset
`define FCS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/fcs_pkg.sv =====
// ----------------------------------------------------------------------------
// fcs_pkg
// Frame geometry, widths and result type for the fire cooling stencil.
// ----------------------------------------------------------------------------
package fcs_pkg;

    // Frame geometry
    localparam int FRAME_WIDTH  = 320;
    localparam int FRAME_HEIGHT = 100;

    // Field widths
    localparam int PIX_W   = 8;
    localparam int COORD_W = 12;
    localparam int ADDR_W  = $clog2(FRAME_WIDTH);
    localparam int SUM_W   = PIX_W + 3;

    // Coordinate constants
    localparam logic [COORD_W-1:0] COL_LAST      = COORD_W'(FRAME_WIDTH - 1);
    localparam logic [COORD_W-1:0] ROW_LAST      = COORD_W'(FRAME_HEIGHT - 1);
    localparam logic [COORD_W-1:0] ROW_OUT_LAST  = COORD_W'(FRAME_HEIGHT - 3);
    localparam logic [COORD_W-1:0] ROW_LAG       = COORD_W'(2);
    localparam logic [COORD_W-1:0] COL_FIRST_INT = COORD_W'(2);

    // Result queue
    localparam int OUTQ_DEPTH = 8;
    localparam int QPTR_W     = $clog2(OUTQ_DEPTH);
    localparam int QCNT_W     = $clog2(OUTQ_DEPTH + 1);

    typedef struct packed {
        logic [PIX_W-1:0]   heat;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               frame_end;
    } heat_result_t;

endpackage

// ===== sv/fcs_ram.sv =====
// ----------------------------------------------------------------------------
// fcs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module fcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 320
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and read-first registered read port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/fire_cooling_stencil.sv =====
// ----------------------------------------------------------------------------
// fire_cooling_stencil
// Streaming 8-neighbour average with cooling over a raster heat frame.
// ----------------------------------------------------------------------------
// One source pixel is taken per clock while s_ready is high. A pixel is
// accepted as its column addresses the two line-buffer RAMs; when the
// registered read data arrive, the buffers are written back, the 3x3 window
// shifts and the results are pushed into an 8-entry result queue, whose
// registered count then raises m_valid for the first result. A write that
// collides with the next read of the same column (back-to-back frame
// starts) is forwarded. Rows 0 and 1 of a frame give no result, column 0
// gives one border result, columns 2 to FRAME_WIDTH-2 one interior result
// each and the last column two. Input is held off only while the result
// queue could not take the results of an item in flight.
module fire_cooling_stencil import fcs_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [PIX_W-1:0]   s_heat_in,
    input  logic               s_frame_start,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [PIX_W-1:0]   m_heat_out,
    output logic [COORD_W-1:0] m_out_row,
    output logic [COORD_W-1:0] m_out_col,
    output logic               m_frame_end
);

    // ------------------------------------------------------------------
    // Stage 0: position counters and line-buffer read
    // ------------------------------------------------------------------
    logic               s_accept;
    logic [COORD_W-1:0] row_reg, row_next;
    logic [COORD_W-1:0] col_reg, col_next;
    logic [COORD_W-1:0] cur_row, cur_col;

    assign s_accept = s_valid && s_ready;
    assign cur_row  = s_frame_start ? '0 : row_reg;
    assign cur_col  = s_frame_start ? '0 : col_reg;

    always_comb begin
        row_next = cur_row;
        col_next = cur_col + COORD_W'(1);
        if (cur_col == COL_LAST) begin
            col_next = '0;
            row_next = (cur_row == ROW_LAST) ? '0 : cur_row + COORD_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (s_accept) begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    logic                 s1_valid_reg;
    logic [PIX_W-1:0]     s1_heat_reg;
    logic [COORD_W-1:0]   s1_row_reg;
    logic [COORD_W-1:0]   s1_col_reg;
    logic                 fwd_hit_reg, fwd_hit_next;
    logic [2*PIX_W-1:0]   fwd_data_reg;
    logic [2*PIX_W-1:0]   line_wr_data;

    // Previous item writes the column we read in the same cycle
    assign fwd_hit_next = s1_valid_reg && (s1_col_reg == cur_col);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s_accept;
            fwd_hit_reg  <= s_accept && fwd_hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_heat_reg <= s_heat_in;
            s1_row_reg  <= cur_row;
            s1_col_reg  <= cur_col;
        end
        fwd_data_reg <= line_wr_data;
    end

    // ------------------------------------------------------------------
    // Line buffers: older row and newer row
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] older_rd, newer_rd;
    logic [PIX_W-1:0] top_pix, mid_pix;

    fcs_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_WIDTH)) u_older_ram (
        .clk     (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg[ADDR_W-1:0]),
        .wr_data (mid_pix),
        .rd_addr (cur_col[ADDR_W-1:0]),
        .rd_data (older_rd)
    );

    fcs_ram #(.WIDTH(PIX_W), .DEPTH(FRAME_WIDTH)) u_newer_ram (
        .clk     (aclk),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_col_reg[ADDR_W-1:0]),
        .wr_data (s1_heat_reg),
        .rd_addr (cur_col[ADDR_W-1:0]),
        .rd_data (newer_rd)
    );

    // Forward the write that raced the read
    assign top_pix      = fwd_hit_reg ? fwd_data_reg[2*PIX_W-1:PIX_W] : older_rd;
    assign mid_pix      = fwd_hit_reg ? fwd_data_reg[PIX_W-1:0]       : newer_rd;
    assign line_wr_data = {mid_pix, s1_heat_reg};

    // ------------------------------------------------------------------
    // 3x3 window: each column packs top, mid, current
    // ------------------------------------------------------------------
    logic [3*PIX_W-1:0] win_reg [3];
    logic [3*PIX_W-1:0] new_column;

    assign new_column = {top_pix, mid_pix, s1_heat_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg[0] <= '0;
            win_reg[1] <= '0;
            win_reg[2] <= '0;
        end else if (s1_valid_reg) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= new_column;
        end
    end

    // Neighbour sum over the shifted window, centre excluded
    logic [SUM_W-1:0] nb_sum;
    logic [PIX_W-1:0] nb_avg;
    logic [PIX_W-1:0] cooled;

    always_comb begin
        nb_sum = SUM_W'(win_reg[1][3*PIX_W-1:2*PIX_W])
               + SUM_W'(win_reg[1][2*PIX_W-1:PIX_W])
               + SUM_W'(win_reg[1][PIX_W-1:0])
               + SUM_W'(win_reg[2][3*PIX_W-1:2*PIX_W])
               + SUM_W'(win_reg[2][PIX_W-1:0])
               + SUM_W'(top_pix)
               + SUM_W'(mid_pix)
               + SUM_W'(s1_heat_reg);
        nb_avg = nb_sum[SUM_W-1:3];
        cooled = (nb_avg != '0) ? nb_avg - PIX_W'(1) : nb_avg;
    end

    // ------------------------------------------------------------------
    // Result selection
    // ------------------------------------------------------------------
    heat_result_t res_a, res_b;
    logic [1:0]   push_cnt;
    logic         row_live;
    logic [COORD_W-1:0] dst_row;

    assign row_live = s1_valid_reg && (s1_row_reg >= ROW_LAG);
    assign dst_row  = s1_row_reg - ROW_LAG;

    always_comb begin
        res_a.heat      = cooled;
        res_a.row       = dst_row;
        res_a.col       = s1_col_reg - COORD_W'(1);
        res_a.frame_end = 1'b0;
        res_b.heat      = top_pix;
        res_b.row       = dst_row;
        res_b.col       = s1_col_reg;
        res_b.frame_end = (s1_row_reg == ROW_LAST);
        push_cnt        = 2'd0;
        if (row_live) begin
            if (s1_col_reg == '0) begin
                // left border passes the older row through
                res_a.heat = top_pix;
                res_a.col  = '0;
                push_cnt   = 2'd1;
            end else if (s1_col_reg >= COL_FIRST_INT) begin
                push_cnt = (s1_col_reg == COL_LAST) ? 2'd2 : 2'd1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    heat_result_t       q_reg [OUTQ_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]  cnt_reg;
    logic               m_pop;
    logic [QCNT_W:0]    credit;

    assign m_valid = (cnt_reg != '0);
    assign m_pop   = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            q_reg[wr_ptr_reg] <= res_a;
        end
        if (push_cnt == 2'd2) begin
            q_reg[wr_ptr_reg + QPTR_W'(1)] <= res_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QPTR_W'(push_cnt);
            rd_ptr_reg <= rd_ptr_reg + QPTR_W'(m_pop);
            cnt_reg    <= cnt_reg + QCNT_W'(push_cnt) - QCNT_W'(m_pop);
        end
    end

    // Room for two results of the item in flight and two of a new one
    assign credit  = (QCNT_W + 1)'(cnt_reg) + (s1_valid_reg ? (QCNT_W + 1)'(2) : '0);
    assign s_ready = (credit <= (QCNT_W + 1)'(OUTQ_DEPTH - 2));

    assign m_heat_out  = q_reg[rd_ptr_reg].heat;
    assign m_out_row   = q_reg[rd_ptr_reg].row;
    assign m_out_col   = q_reg[rd_ptr_reg].col;
    assign m_frame_end = q_reg[rd_ptr_reg].frame_end;

endmodule

// ===== sv/fcs_checker.sv =====
// ----------------------------------------------------------------------------
// fcs_checker
// Port-level checks on the fire cooling stencil result stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fcs_checker import fcs_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [PIX_W-1:0]   m_heat_out,
    input logic [COORD_W-1:0] m_out_row,
    input logic [COORD_W-1:0] m_out_col,
    input logic               m_frame_end
);

    // A stalled transaction holds
    `FCS_ASSERT(a_out_hold, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_heat_out) && $stable(m_out_row) && $stable(m_out_col) && $stable(m_frame_end)), "stalled result changed")

    // Destination coordinates stay inside the produced area
    `FCS_ASSERT(a_out_range, aclk, aresetn, m_valid |-> ((m_out_col <= COL_LAST) && (m_out_row <= ROW_OUT_LAST)), "result coordinate out of range")

    // Frame end marks only the last destination pixel
    `FCS_ASSERT(a_frame_end_pos, aclk, aresetn, (m_valid && m_frame_end) |-> ((m_out_col == COL_LAST) && (m_out_row == ROW_OUT_LAST)), "frame end on wrong pixel")

    // Result queue is empty after reset
    `FCS_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind fire_cooling_stencil fcs_checker u_fcs_checker (.*);
